// ----- design/rrfq_pkg.sv -----
// Shared types and status codes for the round-robin fair queueing scheduler.
package rrfq_pkg;

    localparam logic [1:0] ST_ACCEPTED = 2'd0;
    localparam logic [1:0] ST_DROPPED  = 2'd1;
    localparam logic [1:0] ST_SERVED   = 2'd2;
    localparam logic [1:0] ST_EMPTY    = 2'd3;

    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_SERVE   = 1'b1;

    // Request as held between the front and back parts.
    typedef struct packed {
        logic        op;
        logic [3:0]  flow;
        logic [47:0] handle;
        logic        counted;
    } req_t;

endpackage

// ----- design/rrfq_ram.sv -----
// Generic single-port-write, registered-read RAM.
module rrfq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- design/rrfq_front.sv -----
// Front part: two-entry request queue between the input channel and the back part.
module rrfq_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  rrfq_pkg::req_t    in_req,
    output logic              q_valid,
    input  logic              q_ready,
    output rrfq_pkg::req_t    q_req
);

    rrfq_pkg::req_t ent_reg [2];
    logic [1:0] cnt_reg;
    logic       rd_reg;
    logic       wr_ptr;
    logic       push;
    logic       pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_req    = ent_reg[rd_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;
    assign wr_ptr   = rd_reg ^ cnt_reg[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
            rd_reg  <= 1'b0;
        end else begin
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
            if (pop) begin
                rd_reg <= ~rd_reg;
            end
        end
        if (push) begin
            ent_reg[wr_ptr] <= in_req;
        end
    end

endmodule

// ----- design/rrfq_back.sv -----
// Back part: per-flow queue bookkeeping, round-robin pick and result register.
module rrfq_back #(
    parameter int NUM_FLOWS        = 16,
    parameter int FLOW_QUEUE_DEPTH = 8,
    parameter int HANDLE_BITS      = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   q_valid,
    output logic                   q_ready,
    input  rrfq_pkg::req_t         q_req,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [1:0]             m_status,
    output logic [3:0]             m_out_flow,
    output logic [15:0]            m_out_handle,
    output logic                   m_callback,
    output logic [7:0]             m_total_queued,
    output logic [3:0]             m_flow_counted
);

    localparam int FW  = (NUM_FLOWS > 1) ? $clog2(NUM_FLOWS) : 1;
    localparam int SW  = (FLOW_QUEUE_DEPTH > 1) ? $clog2(FLOW_QUEUE_DEPTH) : 1;
    localparam int OW  = $clog2(FLOW_QUEUE_DEPTH + 1);
    localparam int TW  = $clog2(NUM_FLOWS * FLOW_QUEUE_DEPTH + 1);
    localparam int AW  = FW + SW;
    localparam int DW  = HANDLE_BITS + 1;
    localparam int DEPTH = NUM_FLOWS * FLOW_QUEUE_DEPTH;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [SW-1:0] head_reg [NUM_FLOWS];
    logic [SW-1:0] tail_reg [NUM_FLOWS];
    logic [OW-1:0] occ_reg  [NUM_FLOWS];
    logic [OW-1:0] cnt_reg  [NUM_FLOWS];
    logic [FW-1:0] ptr_reg;
    logic [TW-1:0] total_reg;
    logic [1:0]    state_reg;
    logic [FW-1:0] sel_reg;
    // RAM read data is registered behind the sel_reg-based address; wait for it
    logic          rdata_wait_reg;

    logic [1:0]    r_status_reg;
    logic [3:0]    r_flow_reg;
    logic [15:0]   r_handle_reg;
    logic          r_cb_reg;
    logic [7:0]    r_total_reg;
    logic [3:0]    r_fcnt_reg;

    logic [NUM_FLOWS-1:0] nonempty;
    logic [NUM_FLOWS-1:0] rot;
    logic                 found;
    logic [FW-1:0]        off;
    logic [FW:0]          pick_sum;
    logic [FW-1:0]        pick;
    logic [FW-1:0]        fidx;
    logic                 flow_ok;
    logic                 full;
    logic                 we;
    logic [AW-1:0]        waddr;
    logic [AW-1:0]        raddr;
    logic [DW-1:0]        rdata;
    logic                 take;
    logic [OW-1:0]        cnt_dec;

    assign fidx    = q_req.flow[FW-1:0];
    assign flow_ok = ({28'd0, q_req.flow} < 32'(NUM_FLOWS)) &&
                     ((FW >= 4) || ((q_req.flow >> FW) == 4'd0));
    assign full    = (occ_reg[fidx] == OW'(FLOW_QUEUE_DEPTH));

    always_comb begin
        for (int i = 0; i < NUM_FLOWS; i++) begin
            nonempty[i] = (occ_reg[i] != '0);
        end
        rot = (nonempty >> ptr_reg) | (nonempty << (NUM_FLOWS - 32'(ptr_reg)));
        found = |nonempty;
        off = '0;
        for (int i = NUM_FLOWS - 1; i >= 0; i--) begin
            if (rot[i]) begin
                off = FW'(i);
            end
        end
        pick_sum = {1'b0, ptr_reg} + {1'b0, off};
        pick = (pick_sum >= (FW+1)'(NUM_FLOWS)) ?
               FW'(pick_sum - (FW+1)'(NUM_FLOWS)) : pick_sum[FW-1:0];
    end

    assign take    = (state_reg == S_IDLE) && q_valid;
    assign q_ready = take;
    assign we      = take && (q_req.op == rrfq_pkg::OP_ENQUEUE) && flow_ok && !full;
    assign waddr   = {fidx, tail_reg[fidx]};
    assign raddr   = {sel_reg, head_reg[sel_reg]};
    assign cnt_dec = (rdata[0] && cnt_reg[sel_reg] != '0) ?
                     cnt_reg[sel_reg] - OW'(1) : cnt_reg[sel_reg];

    rrfq_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_store (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata ({q_req.handle[HANDLE_BITS-1:0], q_req.counted}),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            rdata_wait_reg <= 1'b0;
            ptr_reg        <= '0;
            total_reg      <= '0;
            for (int i = 0; i < NUM_FLOWS; i++) begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
                occ_reg[i]  <= '0;
                cnt_reg[i]  <= '0;
            end
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (q_valid) begin
                        r_handle_reg <= '0;
                        r_cb_reg     <= 1'b0;
                        r_flow_reg   <= q_req.flow;
                        r_total_reg  <= 8'(total_reg);
                        state_reg    <= S_OUT;
                        if (q_req.op == rrfq_pkg::OP_ENQUEUE) begin
                            if (!flow_ok) begin
                                r_status_reg <= rrfq_pkg::ST_DROPPED;
                                r_fcnt_reg   <= '0;
                            end else if (full) begin
                                r_status_reg <= rrfq_pkg::ST_DROPPED;
                                r_fcnt_reg   <= 4'(cnt_reg[fidx]);
                            end else begin
                                r_status_reg <= rrfq_pkg::ST_ACCEPTED;
                                tail_reg[fidx] <= (tail_reg[fidx] == SW'(FLOW_QUEUE_DEPTH-1))
                                                  ? '0 : tail_reg[fidx] + SW'(1);
                                occ_reg[fidx]  <= occ_reg[fidx] + OW'(1);
                                total_reg      <= total_reg + TW'(1);
                                r_total_reg    <= 8'(total_reg + TW'(1));
                                cnt_reg[fidx]  <= cnt_reg[fidx] + OW'(q_req.counted);
                                r_fcnt_reg     <= 4'(cnt_reg[fidx] + OW'(q_req.counted));
                            end
                        end else if (!found) begin
                            r_status_reg <= rrfq_pkg::ST_EMPTY;
                            r_flow_reg   <= '0;
                            r_fcnt_reg   <= '0;
                        end else begin
                            // read the head entry next cycle
                            sel_reg   <= pick;
                            state_reg <= S_READ;
                        end
                    end
                end
                S_READ: begin
                    if (!rdata_wait_reg) begin
                        rdata_wait_reg <= 1'b1;
                    end else begin
                        rdata_wait_reg <= 1'b0;
                        r_status_reg <= rrfq_pkg::ST_SERVED;
                        r_flow_reg   <= 4'(sel_reg);
                        r_handle_reg <= 16'(rdata[DW-1:1]);
                        r_cb_reg     <= rdata[0];
                        cnt_reg[sel_reg]  <= cnt_dec;
                        r_fcnt_reg        <= 4'(cnt_dec);
                        head_reg[sel_reg] <= (head_reg[sel_reg] == SW'(FLOW_QUEUE_DEPTH-1))
                                             ? '0 : head_reg[sel_reg] + SW'(1);
                        occ_reg[sel_reg]  <= occ_reg[sel_reg] - OW'(1);
                        total_reg   <= total_reg - TW'(1);
                        r_total_reg <= 8'(total_reg - TW'(1));
                        ptr_reg <= (sel_reg == FW'(NUM_FLOWS-1)) ? '0 : sel_reg + FW'(1);
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (m_ready) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_valid        = (state_reg == S_OUT);
    assign m_status       = r_status_reg;
    assign m_out_flow     = r_flow_reg;
    assign m_out_handle   = r_handle_reg;
    assign m_callback     = r_cb_reg;
    assign m_total_queued = r_total_reg;
    assign m_flow_counted = r_fcnt_reg;

endmodule

// ----- design/per_flow_round_robin_scheduler.sv -----
// Top level of the per-flow round-robin packet scheduler.
//
// Input channel (s_*): one request per handshake. op 0 appends handle to the
// FIFO of flow; op 1 pops the oldest handle of the next non-empty flow at or
// after the round-robin pointer. Output channel (m_*): one result per request
// with status, flow, handle, callback and the occupancy counts after it.
// An enqueue goes from S_IDLE straight to S_OUT; a serve first passes through
// S_READ to wait for the registered read of the shared packet memory. One request is
// worked at a time; a two-entry queue in front keeps accepting while a result
// waits. The flow pick is a rotating priority encoder over per-flow
// non-empty bits, computed combinationally.
// Reset (aresetn low, synchronous) empties all flow queues, clears counters
// and the pointer; packet memory contents are not cleared.
// While m_ready is low the result holds and the input queue fills, then
// s_ready drops.
module per_flow_round_robin_scheduler #(
    parameter int NUM_FLOWS        = 16,
    parameter int FLOW_QUEUE_DEPTH = 8,
    parameter int HANDLE_BITS      = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_op,
    input  logic [3:0]  s_flow,
    input  logic [15:0] s_handle,
    input  logic        s_counted,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [3:0]  m_out_flow,
    output logic [15:0] m_out_handle,
    output logic        m_callback,
    output logic [7:0]  m_total_queued,
    output logic [3:0]  m_flow_counted
);

    rrfq_pkg::req_t in_req;
    rrfq_pkg::req_t q_req;
    logic           q_valid;
    logic           q_ready;

    always_comb begin
        in_req         = '0;
        in_req.op      = s_op;
        in_req.flow    = s_flow;
        in_req.handle  = 48'(s_handle);
        in_req.counted = s_counted;
    end

    rrfq_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_ready (s_ready),
        .in_req   (in_req),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_req    (q_req)
    );

    rrfq_back #(
        .NUM_FLOWS        (NUM_FLOWS),
        .FLOW_QUEUE_DEPTH (FLOW_QUEUE_DEPTH),
        .HANDLE_BITS      (HANDLE_BITS)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_valid        (q_valid),
        .q_ready        (q_ready),
        .q_req          (q_req),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_out_flow     (m_out_flow),
        .m_out_handle   (m_out_handle),
        .m_callback     (m_callback),
        .m_total_queued (m_total_queued),
        .m_flow_counted (m_flow_counted)
    );

endmodule

// ----- sim/tb.sv -----
// Self-checking testbench for the per-flow round-robin packet scheduler.
module tb;

    typedef struct packed {
        logic        op;
        logic [3:0]  flow;
        logic [15:0] handle;
        logic        counted;
    } pkt_req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  out_flow;
        logic [15:0] out_handle;
        logic        callback;
        logic [7:0]  total_queued;
        logic [3:0]  flow_counted;
    } sched_res_t;

    localparam int FLOWS = 16;
    localparam int DEPTH = 8;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_op = rrfq_pkg::OP_ENQUEUE;
    logic [3:0]  s_flow = '0;
    logic [15:0] s_handle = '0;
    logic        s_counted = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_status;
    logic [3:0]  m_out_flow;
    logic [15:0] m_out_handle;
    logic        m_callback;
    logic [7:0]  m_total_queued;
    logic [3:0]  m_flow_counted;

    per_flow_round_robin_scheduler u_top (.*);

    always #5 aclk = ~aclk;

    // Shadow scheduler state.
    logic [16:0] shadow_fifo [FLOWS][$];
    logic [3:0]  shadow_counted [FLOWS];
    logic [3:0]  shadow_ptr;
    logic [7:0]  shadow_total;

    pkt_req_t   pending_reqs [$];
    sched_res_t expected_results [$];
    int send_idle_pct;
    int recv_idle_pct;
    int mismatches;
    bit stim_done;

    function automatic sched_res_t schedule_step(pkt_req_t r);
        sched_res_t res;
        logic [3:0] f;
        logic [16:0] entry;
        res = '0;
        if (r.op == rrfq_pkg::OP_ENQUEUE) begin
            res.out_flow = r.flow;
            if (shadow_fifo[r.flow].size() >= DEPTH) begin
                res.status = rrfq_pkg::ST_DROPPED;
            end else begin
                shadow_fifo[r.flow].push_back({r.handle, r.counted});
                shadow_total++;
                if (r.counted) shadow_counted[r.flow]++;
                res.status = rrfq_pkg::ST_ACCEPTED;
            end
            res.flow_counted = shadow_counted[r.flow];
            res.total_queued = shadow_total;
            return res;
        end
        f = shadow_ptr;
        for (int i = 0; i < FLOWS; i++) begin
            if (shadow_fifo[f].size() != 0) begin
                entry = shadow_fifo[f].pop_front();
                shadow_total--;
                if (entry[0] && shadow_counted[f] != 0) shadow_counted[f]--;
                shadow_ptr = f + 4'd1;
                res.status = rrfq_pkg::ST_SERVED;
                res.out_flow = f;
                res.out_handle = entry[16:1];
                res.callback = entry[0];
                res.flow_counted = shadow_counted[f];
                res.total_queued = shadow_total;
                return res;
            end
            f = f + 4'd1;
        end
        res.status = rrfq_pkg::ST_EMPTY;
        res.total_queued = shadow_total;
        return res;
    endfunction

    // Driver: hold the request until accepted, then advance.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (!s_valid || s_ready) begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    pkt_req_t r;
                    r = pending_reqs.pop_front();
                    expected_results.push_back(schedule_step(r));
                    s_valid <= 1'b1;
                    s_op <= r.op;
                    s_flow <= r.flow;
                    s_handle <= r.handle;
                    s_counted <= r.counted;
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Monitor.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sched_res_t got;
            sched_res_t exp;
            got = {m_status, m_out_flow, m_out_handle, m_callback,
                   m_total_queued, m_flow_counted};
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
            end else begin
                exp = expected_results.pop_front();
                if (got !== exp) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp st=%0d fl=%0d h=%h cb=%0d tot=%0d fc=%0d",
                                  " got st=%0d fl=%0d h=%h cb=%0d tot=%0d fc=%0d"},
                                 exp.status, exp.out_flow, exp.out_handle, exp.callback,
                                 exp.total_queued, exp.flow_counted,
                                 got.status, got.out_flow, got.out_handle, got.callback,
                                 got.total_queued, got.flow_counted);
                end
            end
        end
    end

    function automatic pkt_req_t make_req(logic op, logic [3:0] flow, logic [15:0] h,
                                          logic c);
        pkt_req_t r;
        r.op = op;
        r.flow = flow;
        r.handle = h;
        r.counted = c;
        return r;
    endfunction

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || s_valid || expected_results.size() != 0)
            @(posedge aclk);
    endtask

    initial begin
        mismatches = 0;
        stim_done = 0;
        shadow_ptr = '0;
        shadow_total = '0;
        for (int i = 0; i < FLOWS; i++) shadow_counted[i] = '0;
        send_idle_pct = 9;
        recv_idle_pct = 45;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: empty serve, extremes, fill one flow past full, wrap.
        pending_reqs.push_back(make_req(rrfq_pkg::OP_SERVE, 4'd0, 16'h0, 1'b0));
        pending_reqs.push_back(make_req(rrfq_pkg::OP_ENQUEUE, 4'd15, 16'hFFFF, 1'b1));
        pending_reqs.push_back(make_req(rrfq_pkg::OP_ENQUEUE, 4'd0, 16'h0000, 1'b0));
        for (int i = 0; i < 9; i++)
            pending_reqs.push_back(make_req(rrfq_pkg::OP_ENQUEUE, 4'd7,
                                            16'(16'hA5A0 + i), i[0]));
        for (int i = 0; i < 12; i++)
            pending_reqs.push_back(make_req(rrfq_pkg::OP_SERVE, 4'hF, 16'hFFFF, 1'b1));
        wait_drained();

        for (int ph = 0; ph < 3; ph++) begin
            if (ph == 1) begin
                send_idle_pct = 45;
                recv_idle_pct = 9;
            end else if (ph == 2) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (int i = 0; i < 130; i++) begin
                // Bias toward enqueues early in a phase so queues fill, then drain.
                int bias;
                bias = (i < 65) ? 35 : 65;
                pending_reqs.push_back(make_req($urandom_range(99) < bias,
                                                (i % 4 == 0) ? 4'($urandom_range(1, 0) * 15) :
                                                4'($urandom_range(15)),
                                                16'($urandom), 1'($urandom)));
            end
            wait_drained();
        end
        repeat (20) @(posedge aclk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end
endmodule

// ----- per_flow_round_robin_scheduler.f -----
design/rrfq_pkg.sv
design/rrfq_ram.sv
design/rrfq_front.sv
design/rrfq_back.sv
design/per_flow_round_robin_scheduler.sv
sim/tb.sv
